// ===== rtl/core/rdc_pkg.sv =====
// shared types, constants and helpers of the radix digit converter
package rdc_pkg;

	// default parameter values
	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_DIGITS_DEF = 32;

	// fixed payload widths
	localparam int VALUE_W = 32;
	localparam int BASE_W  = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 7;

	// radix limits and ascii mapping
	localparam logic [BASE_W-1:0]  RADIX_MIN     = BASE_W'(2);
	localparam logic [BASE_W-1:0]  RADIX_MAX     = BASE_W'(16);
	localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = DIGIT_W'(10);
	localparam logic [CHAR_W-1:0]  ASCII_ZERO    = CHAR_W'(48);
	localparam logic [CHAR_W-1:0]  ASCII_ALPHA   = CHAR_W'(55);

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_SHOW
	} rdc_state_t;

	// ascii character of one digit, 0-9 then A-F
	function automatic logic [CHAR_W-1:0] digit_char_of(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] ext;
		ext = CHAR_W'(d);
		if (d < DECIMAL_LIMIT) begin
			return ASCII_ZERO + ext;
		end else begin
			return ASCII_ALPHA + ext;
		end
	endfunction

endpackage

// ===== rtl/core/rdc_num_if.sv =====
// channel carrying the value to convert and its radix
interface rdc_num_if;
	logic                         valid;
	logic                         ready;
	logic [rdc_pkg::VALUE_W-1:0]  value;
	logic [rdc_pkg::BASE_W-1:0]   base;

	modport source (output valid, output value, output base, input ready);
	modport sink   (input valid, input value, input base, output ready);
endinterface

// ===== rtl/core/rdc_dig_if.sv =====
// channel carrying one converted digit
interface rdc_dig_if;
	logic                         valid;
	logic                         ready;
	logic [rdc_pkg::DIGIT_W-1:0]  digit;
	logic [rdc_pkg::CHAR_W-1:0]   digit_char;
	logic                         last_digit;

	modport source (output valid, output digit, output digit_char, output last_digit, input ready);
	modport sink   (input valid, input digit, input digit_char, input last_digit, output ready);
endinterface

// ===== rtl/core/radix_digit_converter_top.sv =====
// Radix digit converter: one value in, its digits out most significant first.
// Each digit comes from a bit-serial restoring divider over QW = min(VALUE_BITS, 32) bits;
// once all digits are divided, each one goes out by a digit store read, then presentation.
// One value at a time: ready returns once the final digit transaction completes.
// Reset clears the sequencer and counters; the digit store is not cleared.
module radix_digit_converter_top #(
	parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF,
	parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rdc_num_if.sink    number,
	rdc_dig_if.source  digits
);

	localparam int QW = (VALUE_BITS < rdc_pkg::VALUE_W) ? VALUE_BITS : rdc_pkg::VALUE_W;
	localparam int BW = $clog2(QW);
	localparam int IW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam int DW = rdc_pkg::DIGIT_W;
	localparam int RW = rdc_pkg::BASE_W;

	rdc_pkg::rdc_state_t state_q, state_d;

	logic [QW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [RW-1:0] rad_q;
	logic [BW-1:0] bit_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] idx_q;
	logic [DW-1:0] rd_q;
	logic [DW-1:0] store_q [MAX_DIGITS];

	logic          in_take;
	logic          out_take;
	logic          div_step;
	logic          div_last;
	logic          div_done;
	logic [RW-1:0] rad_in;
	logic [RW-1:0] rsh;
	logic [RW-1:0] rdiff;
	logic          ge;
	logic [DW-1:0] rem_d;
	logic [QW-1:0] quo_d;
	logic [CW-1:0] cnt_inc;

	// radix saturation on the incoming base
	always_comb begin
		if (number.base < rdc_pkg::RADIX_MIN) begin
			rad_in = rdc_pkg::RADIX_MIN;
		end else if (number.base > rdc_pkg::RADIX_MAX) begin
			rad_in = rdc_pkg::RADIX_MAX;
		end else begin
			rad_in = number.base;
		end
	end

	// one restoring division step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rsh     = {rem_q, quo_q[QW-1]};
		ge      = (rsh >= rad_q);
		rdiff   = rsh - rad_q;
		rem_d   = ge ? rdiff[DW-1:0] : rsh[DW-1:0];
		quo_d   = {quo_q[QW-2:0], ge};
		cnt_inc = cnt_q + CW'(1);
		div_last = (bit_q == '0);
		div_done = div_last && ((quo_d == '0) || (cnt_inc == CW'(MAX_DIGITS)));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rdc_pkg::ST_IDLE: begin
				if (number.valid) state_d = rdc_pkg::ST_DIV;
			end
			rdc_pkg::ST_DIV: begin
				if (div_done) state_d = rdc_pkg::ST_READ;
			end
			rdc_pkg::ST_READ: begin
				state_d = rdc_pkg::ST_SHOW;
			end
			rdc_pkg::ST_SHOW: begin
				if (digits.ready) begin
					state_d = (idx_q == '0) ? rdc_pkg::ST_IDLE : rdc_pkg::ST_READ;
				end
			end
			default: state_d = rdc_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		number.ready = 1'b0;
		digits.valid = 1'b0;
		div_step     = 1'b0;
		unique case (state_q)
			rdc_pkg::ST_IDLE: number.ready = 1'b1;
			rdc_pkg::ST_DIV:  div_step     = 1'b1;
			rdc_pkg::ST_READ: ;
			rdc_pkg::ST_SHOW: digits.valid = 1'b1;
			default: ;
		endcase
	end

	assign in_take  = number.valid && number.ready;
	assign out_take = digits.valid && digits.ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// divider and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q <= '0;
			rem_q <= '0;
			rad_q <= rdc_pkg::RADIX_MIN;
			bit_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
		end else if (in_take) begin
			quo_q <= number.value[QW-1:0];
			rem_q <= '0;
			rad_q <= rad_in;
			bit_q <= BW'(QW - 1);
			cnt_q <= '0;
		end else if (div_step) begin
			quo_q <= quo_d;
			if (div_last) begin
				rem_q <= '0;
				bit_q <= BW'(QW - 1);
				cnt_q <= cnt_inc;
				idx_q <= cnt_q[IW-1:0];
			end else begin
				rem_q <= rem_d;
				bit_q <= bit_q - BW'(1);
			end
		end else if (out_take && (idx_q != '0)) begin
			idx_q <= idx_q - IW'(1);
		end
	end

	// digit store write, one remainder per division
	always_ff @(posedge clk) begin
		if (div_step && div_last) begin
			store_q[cnt_q[IW-1:0]] <= rem_d;
		end
	end

	// digit store read, registered
	always_ff @(posedge clk) begin
		if (state_q == rdc_pkg::ST_READ) begin
			rd_q <= store_q[idx_q];
		end
	end

	// digit transaction payload
	assign digits.digit      = rd_q;
	assign digits.digit_char = rdc_pkg::digit_char_of(rd_q);
	assign digits.last_digit = (idx_q == '0);

endmodule

// ===== verif/radix_digit_converter_top_tb.sv =====
// testbench for the radix digit converter: directed table then random values, digits checked in order
module radix_digit_converter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// widths and constants taken from the package
	localparam int VALUE_W = rdc_pkg::VALUE_W;
	localparam int BASE_W  = rdc_pkg::BASE_W;
	localparam int DIGIT_W = rdc_pkg::DIGIT_W;
	localparam int CHAR_W  = rdc_pkg::CHAR_W;
	localparam logic [BASE_W-1:0]  RADIX_MIN     = rdc_pkg::RADIX_MIN;
	localparam logic [BASE_W-1:0]  RADIX_MAX     = rdc_pkg::RADIX_MAX;
	localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = rdc_pkg::DECIMAL_LIMIT;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO    = rdc_pkg::ASCII_ZERO;
	localparam logic [CHAR_W-1:0]  ASCII_ALPHA   = rdc_pkg::ASCII_ALPHA;

	localparam int NUM_DIRECTED = 24;
	localparam int NUM_RANDOM   = 300;
	localparam int MAX_REPORTS  = 40;
	localparam int DRAIN_EVERY  = 75;
	localparam int TAIL_CYCLES  = 40;

	// one expected digit transaction
	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic [CHAR_W-1:0]  digit_char;
		logic               last_digit;
	} digit_rec_t;

	// one row of the directed table; an empty digit string means use the predictor
	typedef struct {
		logic [VALUE_W-1:0] value;
		logic [BASE_W-1:0]  base;
		string              known;
	} number_row_t;

	logic clk;
	logic arst_n;

	rdc_num_if number_ch ();
	rdc_dig_if digit_ch ();

	radix_digit_converter_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number_ch),
		.digits (digit_ch)
	);

	digit_rec_t  pending_digits [$];
	number_row_t directed_rows [0:NUM_DIRECTED-1];
	int          error_count;
	bit          no_stall;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard limit on run length
	initial begin
		#25_000_000;
		$display("tb: failure");
		$finish;
	end

	// one line per mismatch, printing capped
	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("mismatch at %0t: %s", $realtime, what);
		end
	endtask

	// ascii code of one digit
	function automatic logic [CHAR_W-1:0] char_of_digit(input logic [DIGIT_W-1:0] d);
		if (d < DECIMAL_LIMIT) begin
			return ASCII_ZERO + CHAR_W'(d);
		end else begin
			return ASCII_ALPHA + CHAR_W'(d);
		end
	endfunction

	// repeated division by the saturated radix, digits queued most significant first
	task automatic predict_digits(input logic [VALUE_W-1:0] value, input logic [BASE_W-1:0] base);
		logic [VALUE_W-1:0] rest;
		logic [BASE_W-1:0]  radix;
		logic [DIGIT_W-1:0] remainders [$];
		digit_rec_t         rec;
		radix = base;
		if (base < RADIX_MIN) begin
			radix = RADIX_MIN;
		end else if (base > RADIX_MAX) begin
			radix = RADIX_MAX;
		end
		rest = value;
		if (rest == '0) begin
			remainders = {remainders, DIGIT_W'(0)};
		end
		while (rest != '0) begin
			remainders = {remainders, DIGIT_W'(rest % VALUE_W'(radix))};
			rest = rest / VALUE_W'(radix);
		end
		for (int i = remainders.size() - 1; i >= 0; i--) begin
			rec.digit      = remainders[i];
			rec.digit_char = char_of_digit(remainders[i]);
			rec.last_digit = (i == 0);
			pending_digits = {pending_digits, rec};
		end
	endtask

	// digits written out by hand in the table
	task automatic queue_known_digits(input string known);
		digit_rec_t rec;
		byte        c;
		for (int i = 0; i < known.len(); i++) begin
			c = known[i];
			rec.digit_char = c[CHAR_W-1:0];
			if (c >= "A") begin
				rec.digit = DIGIT_W'(c[CHAR_W-1:0] - ASCII_ALPHA);
			end else begin
				rec.digit = DIGIT_W'(c[CHAR_W-1:0] - ASCII_ZERO);
			end
			rec.last_digit = (i == known.len() - 1);
			pending_digits = {pending_digits, rec};
		end
	endtask

	// drive one number transaction, entered and left at a falling edge
	task automatic send_number(input logic [VALUE_W-1:0] value, input logic [BASE_W-1:0] base,
			input string known);
		int gap;
		gap = no_stall ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			number_ch.valid <= 1'b0;
			number_ch.value <= $urandom;
			number_ch.base  <= BASE_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		number_ch.valid <= 1'b1;
		number_ch.value <= value;
		number_ch.base  <= base;
		do @(posedge clk); while (!(number_ch.valid && number_ch.ready));
		if (known.len() > 0) begin
			queue_known_digits(known);
		end else begin
			predict_digits(value, base);
		end
		@(negedge clk);
	endtask

	// hold off the sender until every digit in flight has come out
	task automatic drain_digits();
		number_ch.valid <= 1'b0;
		while (pending_digits.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	// digit receiver with random stalls, checks each transaction against the oldest expectation
	initial begin
		digit_rec_t want;
		int         stall;
		digit_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = no_stall ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				digit_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			digit_ch.ready <= 1'b1;
			do @(posedge clk); while (!(digit_ch.valid && digit_ch.ready));
			if (pending_digits.size() == 0) begin
				report_mismatch($sformatf("unexpected digit %0h", digit_ch.digit));
			end else begin
				want = pending_digits.pop_front();
				if (digit_ch.digit !== want.digit) begin
					report_mismatch($sformatf("digit %0h, expected %0h",
						digit_ch.digit, want.digit));
				end
				if (digit_ch.digit_char !== want.digit_char) begin
					report_mismatch($sformatf("digit_char %0d, expected %0d",
						digit_ch.digit_char, want.digit_char));
				end
				if (digit_ch.last_digit !== want.last_digit) begin
					report_mismatch($sformatf("last_digit %0b, expected %0b",
						digit_ch.last_digit, want.last_digit));
				end
			end
			@(negedge clk);
		end
	end

	// reset, directed table, random values, end of run
	initial begin
		logic [VALUE_W-1:0] value;
		logic [BASE_W-1:0]  base;
		int                 kind;
		error_count     = 0;
		no_stall        = 1'b0;
		arst_n          = 1'b0;
		number_ch.valid = 1'b0;
		number_ch.value = '0;
		number_ch.base  = '0;

		directed_rows = '{
			'{32'h0000_0000, 5'd10, "0"},
			'{32'h0000_0000, 5'd2,  "0"},
			'{32'h0000_0000, 5'd16, "0"},
			'{32'h0000_0001, 5'd2,  "1"},
			'{32'hFFFF_FFFF, 5'd2,  "11111111111111111111111111111111"},
			'{32'hFFFF_FFFF, 5'd16, "FFFFFFFF"},
			'{32'hFFFF_FFFF, 5'd10, "4294967295"},
			'{32'hFFFF_FFFF, 5'd8,  "37777777777"},
			'{32'h8000_0000, 5'd2,  "10000000000000000000000000000000"},
			'{32'h8000_0000, 5'd16, "80000000"},
			'{32'd9,         5'd10, "9"},
			'{32'd10,        5'd10, "10"},
			'{32'd10,        5'd16, "A"},
			'{32'd15,        5'd16, "F"},
			'{32'd16,        5'd16, "10"},
			// radix below two saturates to binary
			'{32'd255,       5'd0,  "11111111"},
			'{32'd255,       5'd1,  "11111111"},
			// radix above sixteen saturates to hex
			'{32'd255,       5'd17, "FF"},
			'{32'd255,       5'd31, "FF"},
			'{32'd35,        5'd3,  ""},
			'{32'd12345,     5'd7,  ""},
			'{32'hDEAD_BEEF, 5'd13, ""},
			'{32'hFFFF_FFFF, 5'd3,  ""},
			'{32'h1234_5678, 5'd11, ""}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part
		foreach (directed_rows[i]) begin
			send_number(directed_rows[i].value, directed_rows[i].base, directed_rows[i].known);
		end
		drain_digits();

		// random part, with back-to-back stretches and occasional full drains
		for (int n = 0; n < NUM_RANDOM; n++) begin
			no_stall = (n >= 100 && n < 140) || (n >= 220 && n < 250);
			if (n % DRAIN_EVERY == DRAIN_EVERY - 1) begin
				drain_digits();
			end
			kind = $urandom_range(0, 9);
			case (kind)
				0: begin
					value = '0;
				end
				1: begin
					value = ($urandom_range(0, 1) == 1) ? '1 : (VALUE_W'(1) << $urandom_range(0, 31));
				end
				2, 3: begin
					value = VALUE_W'($urandom_range(1, 255));
				end
				4, 5: begin
					value = VALUE_W'($urandom_range(0, 65535));
				end
				default: begin
					value = $urandom;
				end
			endcase
			if ($urandom_range(0, 9) == 0) begin
				base = BASE_W'($urandom_range(0, 31));
			end else begin
				base = BASE_W'($urandom_range(RADIX_MIN, RADIX_MAX));
			end
			send_number(value, base, "");
		end
		no_stall = 1'b0;
		number_ch.valid <= 1'b0;

		// wait out all digits, then a short tail for stray transactions
		while (pending_digits.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== radix_digit_converter_top.f =====
rtl/core/rdc_pkg.sv
rtl/core/rdc_num_if.sv
rtl/core/rdc_dig_if.sv
rtl/core/radix_digit_converter_top.sv
verif/radix_digit_converter_top_tb.sv
